// File: hdl/cfgr_pkg.sv
// ----------------------------------------------------------------------------
// cfgr_pkg
// Shared constants, types and helper functions of the center-to-face grid
// resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package cfgr_pkg;

  // Grid limits and sample format.
  localparam int MAX_DIM      = 128;
  localparam int PLANE_DEPTH  = 16384;  // power of two: address wraps modulo depth
  localparam int SAMPLE_WIDTH = 32;

  // Field widths fixed by the interface.
  localparam int IDX_W  = 22;
  localparam int RES_W  = 8;
  localparam int CIDX_W = 3;

  // Derived widths.
  localparam int SMP_W  = SAMPLE_WIDTH;
  localparam int POS_W  = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(PLANE_DEPTH);
  localparam int RXY_W  = 2 * RES_W;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_AXIS  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_RES_X = 3'd2;
  localparam logic [CIDX_W-1:0] REG_RES_Y = 3'd3;
  localparam logic [CIDX_W-1:0] REG_RES_Z = 3'd4;

  // Axis codes; any other code selects z.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  // Up to three results caused by one input word, in output order.
  typedef struct packed {
    logic [1:0]                  cnt;
    logic                        last_cell;
    logic [2:0][IDX_W-1:0]       idx;
    logic [2:0][SMP_W-1:0]       val;
  } group_t;

  // Resolution register value limited to the supported range.
  function automatic logic [RES_W-1:0] clamp_res(input logic [RES_W-1:0] v);
    logic [RES_W-1:0] r;
    if (v < RES_W'(2)) begin
      r = RES_W'(2);
    end else if (v > RES_W'(MAX_DIM)) begin
      r = RES_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Saturate a widened signed value to the sample range.
  function automatic logic [SMP_W-1:0] sat_smp(input logic signed [SMP_W+2:0] t);
    logic [SMP_W-1:0] r;
    if ((t[SMP_W+2:SMP_W-1] == '0) || (t[SMP_W+2:SMP_W-1] == '1)) begin
      r = t[SMP_W-1:0];
    end else if (t[SMP_W+2]) begin
      r = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SMP_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/center_to_face_grid_resample.sv
// ----------------------------------------------------------------------------
// center_to_face_grid_resample
// Resamples one cell-centered velocity component of a 3D grid to face
// centers along a chosen axis, or passes the samples through.
//
//   channel   signals                                         direction
//   -------   ---------------------------------------------   ---------
//   input     in_valid, in_stall, velocity_sample             in
//   output    out_valid, out_stall, face_index, face_value,   out
//             last_of_item, grid_done
//   config    cfg_we, cfg_index, cfg_data                     in
//
// One input word per cycle while the output flows; a word that causes two or
// three results holds the input until they have left, one result per cycle.
// Registers from acceptance to first result: delay store read, result buffer.
// Reset loads the register defaults and restarts the grid; the delay store
// is not cleared. in_stall is high while the face stage holds a word that the
// result buffer cannot take this cycle, so a stalled output backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module center_to_face_grid_resample
  import cfgr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Configuration port.
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [RES_W-1:0]  cfg_data,
  // Input channel.
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [SMP_W-1:0]  velocity_sample,
  // Output channel.
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [IDX_W-1:0]       face_index,
  output logic [SMP_W-1:0]       face_value,
  output logic                   last_of_item,
  output logic                   grid_done
);

  // Stage 1 payload: one accepted word with everything the face math needs.
  typedef struct packed {
    logic              mode;
    logic              use_ram;
    logic [SMP_W-1:0]  prev;
    logic [SMP_W-1:0]  smp;
    logic              p_zero;
    logic              p_one;
    logic              p_last;
    logic              last_cell;
    logic [IDX_W-1:0]  mid_idx;
    logic [IDX_W-1:0]  stride;
  } stage_t;

  // Configuration registers.
  logic              mode;
  logic [1:0]        axis;
  logic [RES_W-1:0]  rx;
  logic [RES_W-1:0]  ry;
  logic [RES_W-1:0]  rz;
  logic              restart;

  // Grid walk state.
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [POS_W-1:0]  pos_z;
  logic [IDX_W-1:0]  cell_cnt;
  logic [IDX_W-1:0]  row_cnt;
  logic [IDX_W-1:0]  plane_off;
  logic [ADDR_W-1:0] plane_pos;
  logic [SMP_W-1:0]  prev_sample;

  // Stage 0 decode.
  logic              accept;
  logic              x_end;
  logic              y_end;
  logic              z_end;
  logic              last_cell;
  logic [POS_W-1:0]  p;
  logic [RES_W-1:0]  n;
  logic [RXY_W-1:0]  rxy;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  stage_t            s0;

  // Stage 1.
  stage_t            s1;
  logic              s1_valid;
  logic [SMP_W-1:0]  ram_rdata;
  logic [SMP_W-1:0]  prev_v;
  logic signed [SMP_W+2:0] pe;
  logic signed [SMP_W+2:0] se;
  logic signed [SMP_W+2:0] sum_mid;
  logic signed [SMP_W+2:0] sum_first;
  logic signed [SMP_W+2:0] sum_last;
  logic [SMP_W-1:0]  val_mid;
  logic [SMP_W-1:0]  val_first;
  logic [SMP_W-1:0]  val_last;
  logic [IDX_W-1:0]  idx_first;
  logic [IDX_W-1:0]  idx_last;
  group_t            grp;
  logic              drain_ready;
  logic              drain_load;

  // Handshake.
  assign in_stall = s1_valid && !drain_ready;
  assign accept   = in_valid && !in_stall;

  // Any write to a known register restarts the grid.
  always_comb begin
    unique case (cfg_index)
      REG_MODE, REG_AXIS, REG_RES_X, REG_RES_Y, REG_RES_Z: restart = cfg_we;
      default:                                             restart = 1'b0;
    endcase
  end

  // Configuration registers; resolutions are stored already clamped.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      axis <= AXIS_X;
      rx   <= RES_W'(MAX_DIM);
      ry   <= RES_W'(MAX_DIM);
      rz   <= RES_W'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode <= cfg_data[0];
        REG_AXIS:  axis <= cfg_data[1:0];
        REG_RES_X: rx   <= clamp_res(cfg_data);
        REG_RES_Y: ry   <= clamp_res(cfg_data);
        REG_RES_Z: rz   <= clamp_res(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Position decode of the incoming word.
  assign x_end     = (RES_W'(pos_x) == rx - RES_W'(1));
  assign y_end     = (RES_W'(pos_y) == ry - RES_W'(1));
  assign z_end     = (RES_W'(pos_z) == rz - RES_W'(1));
  assign last_cell = x_end && y_end && z_end;
  assign rxy       = RXY_W'(rx) * RXY_W'(ry);

  always_comb begin
    unique case (axis)
      AXIS_X: begin
        p = pos_x;
        n = rx;
      end
      AXIS_Y: begin
        p = pos_y;
        n = ry;
      end
      default: begin
        p = pos_z;
        n = rz;
      end
    endcase
  end

  // Delay store: previous row for y, previous plane for z.
  assign ram_addr = (axis == AXIS_Y) ? ADDR_W'(pos_x) : plane_pos;
  assign ram_we   = accept && (axis != AXIS_X);

  cfgr_ram #(
    .WIDTH (SMP_W),
    .DEPTH (PLANE_DEPTH)
  ) u_delay_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (velocity_sample),
    .re    (accept),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Stage 0 word: the middle face index is the cell count plus an axis offset,
  // the first and last faces sit one stride before and after it.
  always_comb begin
    s0.mode      = mode;
    s0.use_ram   = (axis != AXIS_X);
    s0.prev      = prev_sample;
    s0.smp       = velocity_sample;
    s0.p_zero    = (p == '0);
    s0.p_one     = (p == POS_W'(1));
    s0.p_last    = (RES_W'(p) == n - RES_W'(1));
    s0.last_cell = last_cell;
    if (!mode) begin
      s0.mid_idx = cell_cnt;
    end else begin
      unique case (axis)
        AXIS_X:  s0.mid_idx = cell_cnt + row_cnt;
        AXIS_Y:  s0.mid_idx = cell_cnt + plane_off;
        default: s0.mid_idx = cell_cnt;
      endcase
    end
    unique case (axis)
      AXIS_X:  s0.stride = IDX_W'(1);
      AXIS_Y:  s0.stride = IDX_W'(rx);
      default: s0.stride = IDX_W'(rxy);
    endcase
  end

  // Grid walk counters.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pos_x     <= '0;
      pos_y     <= '0;
      pos_z     <= '0;
      cell_cnt  <= '0;
      row_cnt   <= '0;
      plane_off <= '0;
      plane_pos <= '0;
    end else if (accept) begin
      pos_x    <= x_end ? '0 : pos_x + POS_W'(1);
      cell_cnt <= last_cell ? '0 : cell_cnt + IDX_W'(1);
      if (x_end) begin
        pos_y   <= y_end ? '0 : pos_y + POS_W'(1);
        row_cnt <= last_cell ? '0 : row_cnt + IDX_W'(1);
      end
      if (x_end && y_end) begin
        pos_z     <= z_end ? '0 : pos_z + POS_W'(1);
        plane_off <= last_cell ? '0 : plane_off + IDX_W'(rx);
        plane_pos <= '0;
      end else begin
        plane_pos <= plane_pos + ADDR_W'(1);
      end
    end
  end

  // Previous sample along x, kept in every mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
    end else if (accept) begin
      prev_sample <= velocity_sample;
    end
  end

  // Stage 1 control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (drain_ready) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s0;
    end
  end

  // Face values: floored mean inside, saturated extrapolation at the ends.
  assign prev_v    = s1.use_ram ? ram_rdata : s1.prev;
  assign pe        = {{3{prev_v[SMP_W-1]}}, prev_v};
  assign se        = {{3{s1.smp[SMP_W-1]}}, s1.smp};
  assign sum_mid   = pe + se;
  assign sum_first = pe + (pe <<< 1) - se;
  assign sum_last  = se + (se <<< 1) - pe;
  assign val_mid   = sum_mid[SMP_W:1];
  assign val_first = sat_smp(sum_first >>> 1);
  assign val_last  = sat_smp(sum_last >>> 1);
  assign idx_first = s1.mid_idx - s1.stride;
  assign idx_last  = s1.mid_idx + s1.stride;

  // Pack the results of this word in output order.
  always_comb begin
    grp.last_cell = s1.last_cell;
    grp.idx       = '0;
    grp.val       = '0;
    if (!s1.mode) begin
      grp.cnt    = 2'd1;
      grp.idx[0] = s1.mid_idx;
      grp.val[0] = s1.smp;
    end else if (s1.p_zero) begin
      grp.cnt = 2'd0;
    end else begin
      grp.cnt    = 2'd1 + {1'b0, s1.p_one} + {1'b0, s1.p_last};
      grp.idx[2] = idx_last;
      grp.val[2] = val_last;
      if (s1.p_one) begin
        grp.idx[0] = idx_first;
        grp.val[0] = val_first;
        grp.idx[1] = s1.mid_idx;
        grp.val[1] = val_mid;
      end else begin
        grp.idx[0] = s1.mid_idx;
        grp.val[0] = val_mid;
        grp.idx[1] = idx_last;
        grp.val[1] = val_last;
      end
    end
  end

  assign drain_load = s1_valid && drain_ready && (grp.cnt != 2'd0);

  cfgr_drain u_drain (
    .clk          (clk),
    .rst          (rst),
    .grp_in       (grp),
    .load         (drain_load),
    .ready        (drain_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .face_index   (face_index),
    .face_value   (face_value),
    .last_of_item (last_of_item),
    .grid_done    (grid_done)
  );

endmodule

`default_nettype wire

// File: hdl/cfgr_ram.sv
// ----------------------------------------------------------------------------
// cfgr_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write of the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfgr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/cfgr_drain.sv
// ----------------------------------------------------------------------------
// cfgr_drain
// Result buffer: holds the results of one input word and hands them out
// one word per cycle on the output channel while out_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module cfgr_drain
  import cfgr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire group_t            grp_in,
  input  wire logic              load,
  output logic                   ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [IDX_W-1:0]       face_index,
  output logic [SMP_W-1:0]       face_value,
  output logic                   last_of_item,
  output logic                   grid_done
);

  group_t     grp;
  logic       grp_valid;
  logic [1:0] ptr;
  logic       fire;
  logic       fin;

  // The last word of the group leaves when ptr reaches the count minus one.
  assign fire  = grp_valid && !out_stall;
  assign last_of_item = (ptr == grp.cnt - 2'd1);
  assign fin   = fire && last_of_item;
  assign ready = !grp_valid || fin;

  assign out_valid = grp_valid;
  assign grid_done = last_of_item && grp.last_cell;

  // Select the current result word.
  always_comb begin
    unique case (ptr)
      2'd0: begin
        face_index = grp.idx[0];
        face_value = grp.val[0];
      end
      2'd1: begin
        face_index = grp.idx[1];
        face_value = grp.val[1];
      end
      2'd2: begin
        face_index = grp.idx[2];
        face_value = grp.val[2];
      end
      default: begin
        face_index = grp.idx[0];
        face_value = grp.val[0];
      end
    endcase
  end

  // Control state of the buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      ptr       <= 2'd0;
    end else if (load) begin
      grp_valid <= 1'b1;
      ptr       <= 2'd0;
    end else if (fin) begin
      grp_valid <= 1'b0;
      ptr       <= 2'd0;
    end else if (fire) begin
      ptr <= ptr + 2'd1;
    end
  end

  // Payload of the buffer.
  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

endmodule

`default_nettype wire
